/* rtl/mm_pkg.sv */
// Shared constants and types for the matrix multiply block.
package mm_pkg;

  localparam int DEF_MAX_DIM   = 8;
  localparam int DEF_ELEM_BITS = 16;

  localparam int PROD_BITS = 35;
  localparam int IDX_BITS  = 3;
  localparam int DIM_BITS  = 4;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic clear;
    logic data_valid;
  } mac_ctl_t;

endpackage

/* rtl/matrix_multiply.sv */
// Top level: element load, sequencer and result output of the matrix multiply.
//
//   channel  signals                         direction  beat
//   in       in_valid in_stall element        input      one element of A, then of B
//   out      out_valid out_stall product ...  output     one element of C, row-major
//   cfg      APB psel penable pwrite paddr    input      rows_a, inner_dim, cols_b
//
// Loading accepts one element per cycle; in_stall is low only while loading.
// Each result element is computed in the one shared MAC: k reads of the
// A and B RAMs, RAM latency, multiply, accumulate and the hand-off to the output.
// The output register holds a beat under out_stall while the next sum runs.
// Reset (synchronous) clears the load count and all valid flags.
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = DEF_MAX_DIM,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ELEM_BITS-1:0] element,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PROD_BITS-1:0] product,
  output logic [IDX_BITS-1:0]         out_row,
  output logic [IDX_BITS-1:0]         out_col,
  output logic                        last
);

  localparam int D  = MAX_DIM * MAX_DIM;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(2 * D + 1);

  localparam logic [1:0] S_LOAD    = 2'd0;
  localparam logic [1:0] S_COMPUTE = 2'd1;
  localparam logic [1:0] S_WAIT    = 2'd2;

  logic [1:0]           state;
  logic                 cfg_wr;
  logic [DW-1:0]        m, k, n;
  logic [CW-1:0]        na, total, load_count;
  logic                 accept, in_a, load_done;
  logic [DW-1:0]        i, j, t;
  logic [AW-1:0]        row_base, b_ptr;
  logic                 issuing, v1;
  logic                 out_free, elem_take, last_elem, start;
  logic [ELEM_BITS-1:0] a_rd, b_rd;
  logic [PROD_BITS-1:0] acc;
  logic                 mac_pend;
  mac_ctl_t             mac_ctl;

  mm_cfg #(.MAX_DIM(MAX_DIM), .DW(DW)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_wr, .m, .k, .n
  );

  assign na        = CW'(m) * CW'(k);
  assign total     = na + CW'(k) * CW'(n);
  assign in_stall  = (state != S_LOAD);
  assign accept    = in_valid && !in_stall;
  assign in_a      = (load_count < na);
  assign load_done = accept && ((load_count + CW'(1)) == total);

  mm_ram #(.WIDTH(ELEM_BITS), .DEPTH(D), .AW(AW)) u_a_ram (
    .clk,
    .we    (accept && in_a),
    .waddr (AW'(load_count)),
    .wdata (element),
    .raddr (row_base + AW'(t)),
    .rdata (a_rd)
  );

  mm_ram #(.WIDTH(ELEM_BITS), .DEPTH(D), .AW(AW)) u_b_ram (
    .clk,
    .we    (accept && !in_a),
    .waddr (AW'(load_count - na)),
    .wdata (element),
    .raddr (b_ptr),
    .rdata (b_rd)
  );

  assign out_free  = !out_valid || !out_stall;
  assign elem_take = (state == S_WAIT) && out_free;
  assign last_elem = (i == DW'(m - DW'(1))) && (j == DW'(n - DW'(1)));
  assign start     = load_done || (elem_take && !last_elem);

  assign mac_ctl.clear      = start;
  assign mac_ctl.data_valid = v1;

  mm_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
    .clk, .rst,
    .ctl     (mac_ctl),
    .a       (a_rd),
    .b       (b_rd),
    .acc,
    .pending (mac_pend)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      issuing    <= 1'b0;
      v1         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      v1 <= issuing;
      if (cfg_wr) begin
        load_count <= '0;
      end else if (accept) begin
        load_count <= load_done ? '0 : load_count + CW'(1);
      end
      if (start) begin
        state   <= S_COMPUTE;
        issuing <= 1'b1;
      end else if (issuing && t == DW'(k - DW'(1))) begin
        issuing <= 1'b0;
      end
      if (state == S_COMPUTE && !issuing && !v1 && !mac_pend) begin
        state <= S_WAIT;
      end
      if (elem_take) begin
        out_valid <= 1'b1;
        if (last_elem) begin
          state <= S_LOAD;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issuing) begin
      t     <= t + DW'(1);
      b_ptr <= b_ptr + AW'(n);
    end
    if (load_done) begin
      i        <= '0;
      j        <= '0;
      t        <= '0;
      row_base <= '0;
      b_ptr    <= '0;
    end else if (elem_take && !last_elem) begin
      t <= '0;
      if (j == DW'(n - DW'(1))) begin
        j        <= '0;
        i        <= i + DW'(1);
        row_base <= row_base + AW'(k);
        b_ptr    <= '0;
      end else begin
        j     <= j + DW'(1);
        b_ptr <= AW'(j) + AW'(1);
      end
    end
    if (elem_take) begin
      product <= acc;
      out_row <= IDX_BITS'(i);
      out_col <= IDX_BITS'(j);
      last    <= last_elem;
    end
  end

endmodule

/* rtl/mm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mm_cfg.sv */
// APB register file for the matrix sizes, with clamped dimension outputs.
module mm_cfg
  import mm_pkg::*;
#(
  parameter int MAX_DIM = DEF_MAX_DIM,
  parameter int DW      = $clog2(MAX_DIM + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic              cfg_wr,
  output logic [DW-1:0]     m,
  output logic [DW-1:0]     k,
  output logic [DW-1:0]     n
);

  logic [DIM_BITS-1:0] rows_a;
  logic [DIM_BITS-1:0] inner_dim;
  logic [DIM_BITS-1:0] cols_b;
  logic [1:0]          idx;
  logic                wr;

  function automatic logic [DW-1:0] clamp(input logic [DIM_BITS-1:0] v);
    if (v == '0) return DW'(1);
    if (int'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;
  assign cfg_wr = wr && (idx == REG_ROWS_A || idx == REG_INNER_DIM || idx == REG_COLS_B);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_BITS'(MAX_DIM);
      inner_dim <= DIM_BITS'(MAX_DIM);
      cols_b    <= DIM_BITS'(MAX_DIM);
    end else if (wr) begin
      case (idx)
        REG_ROWS_A:    rows_a    <= pwdata[DIM_BITS-1:0];
        REG_INNER_DIM: inner_dim <= pwdata[DIM_BITS-1:0];
        REG_COLS_B:    cols_b    <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS_A:    prdata = APB_DW'(rows_a);
      REG_INNER_DIM: prdata = APB_DW'(inner_dim);
      REG_COLS_B:    prdata = APB_DW'(cols_b);
      default:       prdata = '0;
    endcase
  end

  assign m = clamp(rows_a);
  assign k = clamp(inner_dim);
  assign n = clamp(cols_b);

endmodule

/* rtl/mm_mac.sv */
// Shared multiply-accumulate unit: registered product, then exact accumulate.
module mm_mac
  import mm_pkg::*;
#(
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mac_ctl_t                    ctl,
  input  logic signed [ELEM_BITS-1:0] a,
  input  logic signed [ELEM_BITS-1:0] b,
  output logic [PROD_BITS-1:0]        acc,
  output logic                        pending
);

  logic signed [2*ELEM_BITS-1:0] prod;
  logic signed [63:0]            prod_ext;

  assign prod_ext = 64'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= ctl.data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.data_valid) begin
      prod <= a * b;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (pending) begin
      acc <= acc + prod_ext[PROD_BITS-1:0];
    end
  end

endmodule
